FILE: design/pprj_pkg.sv
`default_nettype none
package pprj_pkg;

    // field and datapath widths
    localparam int DIFF_W      = 16;
    localparam int ACC_W       = 32;
    localparam int DEPTH_W     = 16;
    localparam int QUOT_W      = 25;
    localparam int DEPTH_SHIFT = 15;
    localparam int AXIS_SHIFT  = 7;
    localparam int TABLE_DEPTH = 9;
    localparam int ROW_LEN     = 3;

    // screen offsets
    localparam logic [15:0] X_OFFSET = 16'd160;
    localparam logic [15:0] Y_OFFSET = 16'd100;

    // command codes
    localparam logic CMD_PROJECT = 1'b0;
    localparam logic CMD_COEFF   = 1'b1;

    // configuration register indexes
    localparam logic [1:0] CFG_CAM_X = 2'd0;
    localparam logic [1:0] CFG_CAM_Y = 2'd1;
    localparam logic [1:0] CFG_CAM_Z = 2'd2;

    // queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    // one projection waiting for division
    typedef struct packed {
        logic signed [QUOT_W-1:0] ax;
        logic signed [QUOT_W-1:0] ay;
        logic [DEPTH_W-1:0]       depth;
    } entry_t;

endpackage
`default_nettype wire

FILE: design/pprj_front.sv
`default_nettype none
module pprj_front #(
    parameter int COEFFICIENT_WIDTH = 32
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_we,
    input  wire logic [1:0]              cfg_index,
    input  wire logic [15:0]             cfg_data,
    input  wire logic                    in_valid,
    output logic                         in_stall,
    input  wire logic                    command,
    input  wire logic [3:0]              coeff_index,
    input  wire logic [31:0]             coeff_value,
    input  wire logic [15:0]             point_x,
    input  wire logic [15:0]             point_y,
    input  wire logic [15:0]             point_z,
    input  wire logic [pprj_pkg::QCNT_W-1:0] q_count,
    output logic                         push,
    output pprj_pkg::entry_t             push_data
);
    import pprj_pkg::*;

    logic [15:0] cam_x_reg, cam_y_reg, cam_z_reg;
    logic signed [COEFFICIENT_WIDTH-1:0] coeff_reg [TABLE_DEPTH];

    logic                     va_reg;
    logic                     cmd_a_reg;
    logic [3:0]               idx_a_reg;
    logic [COEFFICIENT_WIDTH-1:0] val_a_reg;
    logic signed [DIFF_W-1:0] diff_a_reg [ROW_LEN];

    logic                     vb_reg;
    logic [ACC_W-1:0]         prod_reg [TABLE_DEPTH];

    logic [QCNT_W-1:0]        credit;
    logic                     accept;
    logic [ACC_W-1:0]         sum0, sum1, sum2;
    logic signed [ACC_W-1:0]  depth_w, ax_w, ay_w;

    // stall while queue plus in-flight items could overflow
    assign credit   = q_count + {{(QCNT_W-1){1'b0}}, va_reg} + {{(QCNT_W-1){1'b0}}, vb_reg};
    assign in_stall = (credit >= QCNT_W'(QDEPTH));
    assign accept   = in_valid && !in_stall;

    // camera registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cam_x_reg <= '0;
            cam_y_reg <= '0;
            cam_z_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CAM_X: cam_x_reg <= cfg_data;
                CFG_CAM_Y: cam_y_reg <= cfg_data;
                CFG_CAM_Z: cam_z_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // input stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else
        begin
            va_reg <= accept;
            vb_reg <= va_reg && (cmd_a_reg == CMD_PROJECT);
        end
    end

    // input stage payload: camera offset with 16-bit wrap
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_a_reg     <= command;
            idx_a_reg     <= coeff_index;
            val_a_reg     <= coeff_value[COEFFICIENT_WIDTH-1:0];
            diff_a_reg[0] <= point_x - cam_x_reg;
            diff_a_reg[1] <= point_y - cam_y_reg;
            diff_a_reg[2] <= point_z - cam_z_reg;
        end
    end

    // coefficient writes and products, in item order
    always_ff @(posedge clk)
    begin
        if (va_reg && (cmd_a_reg == CMD_COEFF) && (idx_a_reg < 4'(TABLE_DEPTH)))
            coeff_reg[idx_a_reg] <= val_a_reg;
        if (va_reg && (cmd_a_reg == CMD_PROJECT))
        begin
            for (int i = 0; i < TABLE_DEPTH; i++)
                prod_reg[i] <= ACC_W'(ACC_W'(diff_a_reg[i % ROW_LEN])
                                      * ACC_W'(coeff_reg[i]));
        end
    end

    // row sums, shifts and depth test
    always_comb
    begin
        sum0    = prod_reg[0] + prod_reg[1] + prod_reg[2];
        sum1    = prod_reg[3] + prod_reg[4] + prod_reg[5];
        sum2    = prod_reg[6] + prod_reg[7] + prod_reg[8];
        depth_w = signed'(sum2) >>> DEPTH_SHIFT;
        ax_w    = signed'(sum0) >>> AXIS_SHIFT;
        ay_w    = signed'(sum1) >>> AXIS_SHIFT;
        push    = vb_reg && !depth_w[ACC_W-1] && (depth_w != '0);
        push_data.ax    = ax_w[QUOT_W-1:0];
        push_data.ay    = ay_w[QUOT_W-1:0];
        push_data.depth = depth_w[DEPTH_W-1:0];
    end

endmodule
`default_nettype wire

FILE: design/pprj_queue.sv
`default_nettype none
module pprj_queue (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        push,
    input  wire pprj_pkg::entry_t            push_data,
    input  wire logic                        pop,
    output pprj_pkg::entry_t                 pop_data,
    output logic [pprj_pkg::QCNT_W-1:0]      count
);
    import pprj_pkg::*;

    entry_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_reg, rd_reg;
    logic [QCNT_W-1:0]   cnt_reg;

    assign count    = cnt_reg;
    assign pop_data = mem_reg[rd_reg];

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= wr_reg + 1'b1;
            if (pop)
                rd_reg <= rd_reg + 1'b1;
            cnt_reg <= cnt_reg + {{(QCNT_W-1){1'b0}}, push} - {{(QCNT_W-1){1'b0}}, pop};
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_data;
    end

endmodule
`default_nettype wire

FILE: design/pprj_back.sv
`default_nettype none
module pprj_back (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic [pprj_pkg::QCNT_W-1:0] q_count,
    input  wire pprj_pkg::entry_t            pop_data,
    output logic                             pop,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic [15:0]                      screen_x,
    output logic [15:0]                      screen_y,
    output logic [15:0]                      depth_out
);
    import pprj_pkg::*;

    localparam int NB = QUOT_W;

    logic [NB:0]          v_reg;
    logic [NB-1:0]        nx_reg [NB+1];
    logic [NB-1:0]        ny_reg [NB+1];
    logic [DEPTH_W-1:0]   rx_reg [NB+1];
    logic [DEPTH_W-1:0]   ry_reg [NB+1];
    logic [DEPTH_W-1:0]   d_reg  [NB+1];
    logic [NB:0]          sx_reg, sy_reg;

    logic [NB-1:0]        nx_next [NB+1];
    logic [NB-1:0]        ny_next [NB+1];
    logic [DEPTH_W-1:0]   rx_next [NB+1];
    logic [DEPTH_W-1:0]   ry_next [NB+1];

    logic                 out_valid_reg;
    logic [15:0]          sxo_reg, syo_reg, dep_reg;
    logic                 adv;
    logic [DEPTH_W:0]     tx, ty;
    logic [15:0]          qx, qy;

    // whole pipeline holds while the output is stalled
    assign adv       = !(out_valid_reg && out_stall);
    assign pop       = adv && (q_count != '0);
    assign out_valid = out_valid_reg;
    assign screen_x  = sxo_reg;
    assign screen_y  = syo_reg;
    assign depth_out = dep_reg;

    // one restoring step per stage for both axes
    always_comb
    begin
        nx_next[0] = pop_data.ax[NB-1] ? NB'(-pop_data.ax) : NB'(pop_data.ax);
        ny_next[0] = pop_data.ay[NB-1] ? NB'(-pop_data.ay) : NB'(pop_data.ay);
        rx_next[0] = '0;
        ry_next[0] = '0;
        tx = '0;
        ty = '0;
        for (int k = 1; k <= NB; k++)
        begin
            tx = {rx_reg[k-1], nx_reg[k-1][NB-1]};
            ty = {ry_reg[k-1], ny_reg[k-1][NB-1]};
            if (tx >= {1'b0, d_reg[k-1]})
            begin
                rx_next[k] = DEPTH_W'(tx - {1'b0, d_reg[k-1]});
                nx_next[k] = {nx_reg[k-1][NB-2:0], 1'b1};
            end
            else
            begin
                rx_next[k] = tx[DEPTH_W-1:0];
                nx_next[k] = {nx_reg[k-1][NB-2:0], 1'b0};
            end
            if (ty >= {1'b0, d_reg[k-1]})
            begin
                ry_next[k] = DEPTH_W'(ty - {1'b0, d_reg[k-1]});
                ny_next[k] = {ny_reg[k-1][NB-2:0], 1'b1};
            end
            else
            begin
                ry_next[k] = ty[DEPTH_W-1:0];
                ny_next[k] = {ny_reg[k-1][NB-2:0], 1'b0};
            end
        end
    end

    // stage valids and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v_reg         <= {v_reg[NB-1:0], pop};
            out_valid_reg <= v_reg[NB];
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            nx_reg[0] <= nx_next[0];
            ny_reg[0] <= ny_next[0];
            rx_reg[0] <= rx_next[0];
            ry_reg[0] <= ry_next[0];
            d_reg[0]  <= pop_data.depth;
            sx_reg[0] <= pop_data.ax[NB-1];
            sy_reg[0] <= pop_data.ay[NB-1];
            for (int k = 1; k <= NB; k++)
            begin
                nx_reg[k] <= nx_next[k];
                ny_reg[k] <= ny_next[k];
                rx_reg[k] <= rx_next[k];
                ry_reg[k] <= ry_next[k];
                d_reg[k]  <= d_reg[k-1];
                sx_reg[k] <= sx_reg[k-1];
                sy_reg[k] <= sy_reg[k-1];
            end
        end
    end

    // signed quotient plus screen offset
    always_comb
    begin
        qx = sx_reg[NB] ? (16'd0 - nx_reg[NB][15:0]) : nx_reg[NB][15:0];
        qy = sy_reg[NB] ? (16'd0 - ny_reg[NB][15:0]) : ny_reg[NB][15:0];
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sxo_reg <= qx + X_OFFSET;
            syo_reg <= qy + Y_OFFSET;
            dep_reg <= d_reg[NB];
        end
    end

endmodule
`default_nettype wire

FILE: design/point_perspective_projector.sv
// point_perspective_projector
// Input channel: in_valid/in_stall with command, coeff_index, coeff_value,
// point_x, point_y, point_z. command 1 loads one coefficient of the 3x3
// matrix (no result); command 0 projects a point.
// Output channel: out_valid/out_stall with screen_x, screen_y, depth_out.
// A point whose depth is not positive gives no result.
// Configuration: cfg_we/cfg_index/cfg_data write the camera position,
// index 0 x, 1 y, 2 z; other indexes are ignored.
// Throughput: one item per cycle while in_stall is low. A result shows on
// out_valid once its item has passed two front stages (offset, products),
// the queue write fed by the row sums and depth test, one load stage, 25
// stages of the pipelined restoring divider and the output register.
// The divider depth follows the 25-bit axis numerator.
// Reset clears the camera registers, the queue and all valids; the
// coefficient table must be loaded before points are projected.
// While a result waits under out_stall the back pipeline holds; the front
// keeps taking items until the queue and its two stages hold four items,
// then raises in_stall.
`default_nettype none
module point_perspective_projector #(
    parameter int COEFFICIENT_WIDTH = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        command,
    input  wire logic [3:0]  coeff_index,
    input  wire logic [31:0] coeff_value,
    input  wire logic [15:0] point_x,
    input  wire logic [15:0] point_y,
    input  wire logic [15:0] point_z,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [15:0]      screen_x,
    output logic [15:0]      screen_y,
    output logic [15:0]      depth_out
);
    import pprj_pkg::*;

    logic              push, pop;
    entry_t            push_data, pop_data;
    logic [QCNT_W-1:0] q_count;

    // accept, coefficient table and dot products
    pprj_front #(
        .COEFFICIENT_WIDTH(COEFFICIENT_WIDTH)
    ) u_front (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .command(command), .coeff_index(coeff_index), .coeff_value(coeff_value),
        .point_x(point_x), .point_y(point_y), .point_z(point_z),
        .q_count(q_count), .push(push), .push_data(push_data)
    );

    // decoupling queue
    pprj_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .push(push), .push_data(push_data),
        .pop(pop), .pop_data(pop_data), .count(q_count)
    );

    // division and output
    pprj_back u_back (
        .clk(clk), .rst_n(rst_n),
        .q_count(q_count), .pop_data(pop_data), .pop(pop),
        .out_valid(out_valid), .out_stall(out_stall),
        .screen_x(screen_x), .screen_y(screen_y), .depth_out(depth_out)
    );

endmodule
`default_nettype wire
